FILE: rtl/izh_pkg.sv
package izh_pkg;

    localparam int NeuronCount = 1024;
    localparam int Substeps    = 4;
    localparam int IdxW        = 10;
    localparam int AddrW       = (NeuronCount > 1) ? $clog2(NeuronCount) : 1;
    localparam int StepW       = (Substeps > 1) ? $clog2(Substeps) : 1;
    localparam int SubShift    = $clog2(Substeps);
    localparam int CfgIdxW     = 3;
    localparam int QueueDepth  = 2;

    localparam logic [CfgIdxW-1:0] CFG_QUAD   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_LIN    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_CONST  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_RATE   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SENS   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_RESETV = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_JUMP   = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_THRESH = 3'd7;

    typedef struct packed {
        logic                command;
        logic [IdxW-1:0]     neuron_index;
        logic signed [31:0]  input_current;
        logic                disabled;
    } t_in_item;

    typedef struct packed {
        logic [IdxW-1:0]     out_index;
        logic                fired;
        logic signed [31:0]  new_voltage;
        logic signed [31:0]  new_recovery;
        logic                updated;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_IGNORE,
        OP_INIT,
        OP_READ_ONLY,
        OP_STEP
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [IdxW-1:0]     neuron_index;
        logic signed [31:0]  input_current;
    } t_job;

    typedef struct packed {
        logic signed [31:0] quad_coeff;
        logic signed [31:0] lin_coeff;
        logic signed [31:0] const_term;
        logic signed [31:0] recovery_rate;
        logic signed [31:0] recovery_sensitivity;
        logic signed [31:0] reset_voltage;
        logic signed [31:0] recovery_jump;
        logic signed [31:0] spike_threshold;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
        logic signed [31:0] r;
        if (x > 65'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -65'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        return sat32(s);
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        return sat32(s);
    endfunction

endpackage

FILE: rtl/izh_ram.sv
module izh_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/izh_front.sv
module izh_front import izh_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output logic     o_job_valid,
    input  logic     i_job_take,
    output t_job     o_job
);
    // classify items into jobs and hold them in a small FIFO
    t_job              r_q [QueueDepth];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    t_job              w_job;
    logic              w_push, w_pop;

    always_comb begin
        w_job.neuron_index  = i_item.neuron_index;
        w_job.input_current = i_item.input_current;
        if (32'(i_item.neuron_index) >= NeuronCount) begin
            w_job.op = OP_IGNORE;
        end else if (i_item.command) begin
            w_job.op = OP_INIT;
        end else if (i_item.disabled) begin
            w_job.op = OP_READ_ONLY;
        end else begin
            w_job.op = OP_STEP;
        end
    end

    assign o_stall     = (r_cnt == 2'(QueueDepth));
    assign w_push      = i_valid && !o_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = o_job_valid && i_job_take;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

FILE: rtl/izh_back.sv
module izh_back import izh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_job_valid,
    output logic      o_job_take,
    input  t_job      i_job,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_LOAD, S_AB, S_SQ, S_QT, S_LT, S_BV, S_AU,
        S_UPD, S_WRITE, S_OUT
    } t_state;

    t_state             r_state;
    t_job               r_job;
    logic signed [31:0] r_v, r_u, r_ab, r_sq, r_qt, r_lt, r_bv, r_au;
    logic [StepW-1:0]   r_step;
    logic               r_fired;
    logic               r_valid;
    t_out_item          r_item;

    // one shared multiplier, registered product
    logic signed [31:0] w_ma, w_mb, r_prod;
    logic signed [63:0] w_full;
    logic               w_we;
    logic [AddrW-1:0]   w_addr;
    logic signed [31:0] w_vrd, w_urd, w_vwr, w_uwr;

    always_comb begin
        unique case (r_state)
            S_AB:    begin w_ma = i_cfg.recovery_rate; w_mb = i_cfg.recovery_sensitivity; end
            S_SQ:    begin w_ma = r_v;                 w_mb = r_v;           end
            S_QT:    begin w_ma = i_cfg.quad_coeff;    w_mb = r_prod;        end
            S_LT:    begin w_ma = i_cfg.lin_coeff;     w_mb = r_v;           end
            S_BV:    begin w_ma = r_ab;                w_mb = r_v;           end
            S_AU:    begin w_ma = i_cfg.recovery_rate; w_mb = r_u;           end
            default: begin w_ma = r_v;                 w_mb = r_v;           end
        endcase
        w_full = 64'(w_ma) * 64'(w_mb);
    end

    always_ff @(posedge i_clk) begin
        // arithmetic shift floors
        r_prod <= sat32(65'(w_full >>> 16));
    end

    assign w_addr = r_job.neuron_index[AddrW-1:0];
    assign w_we   = (r_state == S_WRITE);
    assign w_vwr  = r_v;
    assign w_uwr  = r_u;

    izh_ram #(.Width(32), .Depth(NeuronCount)) u_vram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_addr), .i_wdata(w_vwr),
        .i_raddr(w_addr), .o_rdata(w_vrd)
    );
    izh_ram #(.Width(32), .Depth(NeuronCount)) u_uram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_addr), .i_wdata(w_uwr),
        .i_raddr(w_addr), .o_rdata(w_urd)
    );

    logic signed [31:0] w_dv, w_du, w_nv, w_nu;
    always_comb begin
        w_dv = qadd(r_qt, r_lt);
        w_dv = qadd(w_dv, i_cfg.const_term);
        w_dv = qsub(w_dv, r_u);
        w_dv = qadd(w_dv, r_job.input_current);
        w_du = qsub(r_bv, r_prod);
        w_nv = qadd(r_v, w_dv >>> SubShift);
        w_nu = qadd(r_u, w_du >>> SubShift);
    end

    assign o_job_take = (r_state == S_IDLE) && i_job_valid;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            // in S_OUT the result register is reloaded or kept below
            if (r_valid && !i_stall && (r_state != S_OUT)) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_job   <= i_job;
                    r_fired <= 1'b0;
                    r_step  <= '0;
                    unique case (i_job.op)
                        OP_IGNORE: begin
                            r_v <= '0; r_u <= '0; r_state <= S_OUT;
                        end
                        OP_INIT: begin
                            r_v <= i_cfg.reset_voltage; r_u <= '0;
                            r_state <= S_WRITE;
                        end
                        default: r_state <= S_READ;
                    endcase
                end
                S_READ: r_state <= S_LOAD;
                S_LOAD: begin
                    r_v <= w_vrd;
                    r_u <= w_urd;
                    r_state <= (r_job.op == OP_STEP) ? S_AB : S_OUT;
                end
                S_AB: r_state <= S_SQ;
                S_SQ: begin
                    // a*b is only on the multiplier output before the first substep
                    if (r_step == '0) r_ab <= r_prod;
                    r_state <= S_QT;
                end
                S_QT: r_state <= S_LT;
                S_LT: begin r_qt <= r_prod; r_state <= S_BV; end
                S_BV: begin r_lt <= r_prod; r_state <= S_AU; end
                S_AU: begin r_bv <= r_prod; r_state <= S_UPD; end
                S_UPD: begin
                    if (w_nv >= i_cfg.spike_threshold) begin
                        r_v     <= i_cfg.reset_voltage;
                        r_u     <= qadd(w_nu, i_cfg.recovery_jump);
                        r_fired <= 1'b1;
                        r_state <= S_WRITE;
                    end else begin
                        r_v <= w_nv;
                        r_u <= w_nu;
                        if (32'(r_step) == Substeps - 1) begin
                            r_state <= S_WRITE;
                        end else begin
                            r_step  <= r_step + 1'b1;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_WRITE: r_state <= S_OUT;
                S_OUT: if (!r_valid || !i_stall) begin
                    r_valid             <= 1'b1;
                    r_item.out_index    <= r_job.neuron_index;
                    r_item.fired        <= r_fired;
                    r_item.new_voltage  <= r_v;
                    r_item.new_recovery <= r_u;
                    r_item.updated      <= (r_job.op == OP_INIT) || (r_job.op == OP_STEP);
                    r_state             <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/izhikevich_neuron_update.sv
// channel | handshake           | payload
// input   | i_valid / o_stall   | i_item (t_in_item)
// output  | o_valid / i_stall   | o_item (t_out_item)
// config  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
// An update holds the back end busy: one shared 32x32 multiplier runs five
// products and an update step per substep, plus a*b once. Init writes the
// tables without a read, disabled items are read but not stepped, out-of-range
// items skip the tables; all pass through the queue. Fewer substeps when the neuron fires early.
// Reset (synchronous) restores registers and empties the queue; tables
// are not cleared. A two-entry queue lets input arrive while a result stalls.
module izhikevich_neuron_update import izh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_in_item           i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output t_out_item          o_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    t_cfg r_cfg;
    logic w_job_valid, w_job_take;
    t_job w_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quad_coeff           <= 32'sd2621;
            r_cfg.lin_coeff            <= 32'sd327680;
            r_cfg.const_term           <= 32'sd9175040;
            r_cfg.recovery_rate        <= 32'sd1311;
            r_cfg.recovery_sensitivity <= 32'sd13107;
            r_cfg.reset_voltage        <= -32'sd4259840;
            r_cfg.recovery_jump        <= 32'sd524288;
            r_cfg.spike_threshold      <= 32'sd1966080;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_QUAD:   r_cfg.quad_coeff           <= i_cfg_data;
                CFG_LIN:    r_cfg.lin_coeff            <= i_cfg_data;
                CFG_CONST:  r_cfg.const_term           <= i_cfg_data;
                CFG_RATE:   r_cfg.recovery_rate        <= i_cfg_data;
                CFG_SENS:   r_cfg.recovery_sensitivity <= i_cfg_data;
                CFG_RESETV: r_cfg.reset_voltage        <= i_cfg_data;
                CFG_JUMP:   r_cfg.recovery_jump        <= i_cfg_data;
                CFG_THRESH: r_cfg.spike_threshold      <= i_cfg_data;
                default:    r_cfg.quad_coeff           <= r_cfg.quad_coeff;
            endcase
        end
    end

    izh_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_job_valid(w_job_valid), .i_job_take(w_job_take),
        .o_job(w_job)
    );

    izh_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_job_valid(w_job_valid), .o_job_take(w_job_take), .i_job(w_job),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );
endmodule
